@@ rtl/core/rc4_stream_cipher_macros.svh @@
// Assertion macros for the RC4 engine checkers.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Property that must hold at every clock edge.
`define RC4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define RC4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rc4_pkg.sv @@
// Shared types and constants for the RC4 engine.
// No dependencies; used by the interfaces, the memories and the controller.
package rc4_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned KEY_LEN_W = 9;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;
  localparam logic [BYTE_W-1:0]    BYTE_MAX      = 8'hFF;

  // Request command codes; code 3 is accepted and ignored.
  typedef enum logic [1:0] {
    CMD_KEY_WRITE = 2'd0,
    CMD_SCHEDULE  = 2'd1,
    CMD_CRYPT     = 2'd2
  } rc4_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_A,   // read S[n] and key[k], write back pending S[j]
    ST_KS_B,   // new j, read S[j]
    ST_KS_C,   // write S[n] = S[j]
    ST_KS_W,   // final pending write, clear indices
    ST_CR_A,   // read S[i]
    ST_CR_B,   // new j, read S[j]
    ST_CR_C,   // write S[i] = S[j]
    ST_CR_D,   // write S[j] = old S[i], read S[S[i]+S[j]]
    ST_CR_E    // keystream byte ready, load output
  } rc4_state_e;

  // One access cycle on the sbox memory.
  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
  } sbox_req_t;

endpackage

@@ rtl/core/rc4_req_if.sv @@
// Request channel of the RC4 engine: command plus key and data fields.
// Depends on rc4_pkg for field widths.
interface rc4_req_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [BYTE_W-1:0] key_index;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] data_in;
  logic              last_in;

  modport source (output valid, command, key_index, key_byte, data_in, last_in,
                  input ready);
  modport sink   (input valid, command, key_index, key_byte, data_in, last_in,
                  output ready);
endinterface

@@ rtl/core/rc4_rsp_if.sv @@
// Response channel of the RC4 engine: processed byte and last marker.
// Depends on rc4_pkg for field widths.
interface rc4_rsp_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic              last_out;

  modport source (output valid, data_out, last_out, input ready);
  modport sink   (input valid, data_out, last_out, output ready);
endinterface

@@ rtl/core/rc4_sbox_ram.sv @@
// 256 x 8 sbox memory: one write and one registered read per cycle.
// Per-entry valid bits make an unwritten entry read as its own address.
// Depends on rc4_pkg.
module rc4_sbox_ram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rc4_pkg::sbox_req_t         req_i,
  output logic [rc4_pkg::BYTE_W-1:0] rd_data_o
);
  import rc4_pkg::*;

  logic [BYTE_W-1:0]     mem [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] valid_q;
  logic [BYTE_W-1:0]     rd_data_q;

  // Valid bits: cleared at once by reset or a new schedule
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  // Storage write
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read, same-address write forwarded
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      if (req_i.wr_en && (req_i.wr_addr == req_i.rd_addr)) begin
        rd_data_q <= req_i.wr_data;
      end else if (valid_q[req_i.rd_addr]) begin
        rd_data_q <= mem[req_i.rd_addr];
      end else begin
        rd_data_q <= req_i.rd_addr;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/rc4_key_ram.sv @@
// Key byte store: one write port and one registered read port.
// Contents are undefined until written. Depends on rc4_pkg.
module rc4_key_ram #(
  parameter  int unsigned KEY_MAX = 256,
  localparam int unsigned KeyAw   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [KeyAw-1:0]           wr_addr_i,
  input  logic [rc4_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [KeyAw-1:0]           rd_addr_i,
  output logic [rc4_pkg::BYTE_W-1:0] rd_data_o
);
  import rc4_pkg::*;

  logic [BYTE_W-1:0] mem [KEY_MAX];
  logic [BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/rc4_ctrl.sv @@
// Sequencer of the RC4 engine: key schedule and keystream rounds over the
// sbox memory, key writes, and the response register.
// Depends on rc4_pkg, rc4_req_if and rc4_rsp_if.
module rc4_ctrl #(
  parameter  int unsigned KEY_MAX = 256,
  localparam int unsigned KeyAw   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rc4_req_if.sink                       req_i,
  rc4_rsp_if.source                     rsp_o,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] key_length_i,
  output rc4_pkg::sbox_req_t            sbox_req_o,
  input  logic [rc4_pkg::BYTE_W-1:0]    sbox_rd_data_i,
  output logic                          key_we_o,
  output logic [KeyAw-1:0]              key_waddr_o,
  output logic [rc4_pkg::BYTE_W-1:0]    key_wdata_o,
  output logic                          key_re_o,
  output logic [KeyAw-1:0]              key_raddr_o,
  input  logic [rc4_pkg::BYTE_W-1:0]    key_rd_data_i
);
  import rc4_pkg::*;

  localparam logic [KEY_LEN_W-1:0] KeyMaxLen = KEY_LEN_W'(KEY_MAX);

  rc4_state_e state_q, state_d;

  logic [BYTE_W-1:0] i_q;     // stream i, also schedule round n
  logic [BYTE_W-1:0] j_q;
  logic [KeyAw-1:0]  k_q;     // key position, n mod length
  logic [BYTE_W-1:0] a_q;     // value read from S[i] / S[n]
  logic [BYTE_W-1:0] din_q;
  logic              lin_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q;

  logic                 accept;
  logic                 out_free;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [KEY_LEN_W-1:0] k_last;
  logic [BYTE_W-1:0]    j_ks;
  logic [BYTE_W-1:0]    j_cr;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // Key length clamped to 1..KEY_MAX
  always_comb begin
    if (key_length_i == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_length_i > KeyMaxLen) begin
      len_eff = KeyMaxLen;
    end else begin
      len_eff = key_length_i;
    end
  end
  assign k_last = len_eff - KEY_LEN_W'(1);

  assign j_ks = BYTE_W'(j_q + sbox_rd_data_i + key_rd_data_i);
  assign j_cr = BYTE_W'(j_q + sbox_rd_data_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.command)
            CMD_SCHEDULE: state_d = ST_KS_A;
            CMD_CRYPT:    state_d = ST_CR_A;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_KS_A: state_d = ST_KS_B;
      ST_KS_B: state_d = ST_KS_C;
      ST_KS_C: state_d = (i_q == BYTE_MAX) ? ST_KS_W : ST_KS_A;
      ST_KS_W: state_d = ST_IDLE;
      ST_CR_A: state_d = ST_CR_B;
      ST_CR_B: state_d = ST_CR_C;
      ST_CR_C: state_d = ST_CR_D;
      ST_CR_D: state_d = ST_CR_E;
      ST_CR_E: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory accesses per state
  always_comb begin
    sbox_req_o = '0;
    key_re_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        sbox_req_o.clr = accept && (req_i.command == CMD_SCHEDULE);
      end
      ST_KS_A: begin
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = i_q;
        // swap half left over from the previous round
        sbox_req_o.wr_en   = (i_q != '0);
        sbox_req_o.wr_addr = j_q;
        sbox_req_o.wr_data = a_q;
        key_re_o           = 1'b1;
      end
      ST_KS_B: begin
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = j_ks;
      end
      ST_KS_C, ST_CR_C: begin
        sbox_req_o.wr_en   = 1'b1;
        sbox_req_o.wr_addr = i_q;
        sbox_req_o.wr_data = sbox_rd_data_i;
      end
      ST_KS_W: begin
        sbox_req_o.wr_en   = 1'b1;
        sbox_req_o.wr_addr = j_q;
        sbox_req_o.wr_data = a_q;
      end
      ST_CR_A: begin
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = i_q;
      end
      ST_CR_B: begin
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = j_cr;
      end
      ST_CR_D: begin
        sbox_req_o.wr_en   = 1'b1;
        sbox_req_o.wr_addr = j_q;
        sbox_req_o.wr_data = a_q;
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = BYTE_W'(a_q + sbox_rd_data_i);
      end
      default: ;
    endcase
  end

  // Key store ports
  assign key_we_o    = accept && (req_i.command == CMD_KEY_WRITE)
                       && (KEY_LEN_W'(req_i.key_index) < KeyMaxLen);
  assign key_waddr_o = req_i.key_index[KeyAw-1:0];
  assign key_wdata_o = req_i.key_byte;
  assign key_raddr_o = k_q;

  assign req_i.ready    = (state_q == ST_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.last_out = out_last_q;

  // Control state and indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept && (req_i.command == CMD_SCHEDULE)) begin
            i_q <= '0;
            j_q <= '0;
            k_q <= '0;
          end else if (accept && (req_i.command == CMD_CRYPT)) begin
            i_q <= i_q + BYTE_W'(1);
          end
        end
        ST_KS_B: j_q <= j_ks;
        ST_KS_C: begin
          if (i_q != BYTE_MAX) begin
            i_q <= i_q + BYTE_W'(1);
            k_q <= (KEY_LEN_W'(k_q) == k_last) ? '0 : k_q + KeyAw'(1);
          end
        end
        ST_KS_W: begin
          i_q <= '0;
          j_q <= '0;
        end
        ST_CR_B: j_q <= j_cr;
        default: ;
      endcase
    end
  end

  // Response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_CR_E) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      din_q <= req_i.data_in;
      lin_q <= req_i.last_in;
    end
    if ((state_q == ST_KS_B) || (state_q == ST_CR_B)) begin
      a_q <= sbox_rd_data_i;
    end
    if ((state_q == ST_CR_E) && out_free) begin
      out_data_q <= din_q ^ sbox_rd_data_i;
      out_last_q <= lin_q;
    end
  end

endmodule

@@ rtl/core/rc4_stream_cipher.sv @@
// Channel  | Dir | Payload                                      | Handshake
// req_i    | in  | command, key_index, key_byte, data_in, last_in | valid/ready
// rsp_o    | out | data_out, last_out                            | valid/ready
// cfg      | in  | key_length_i (9 bits)                         | key_length_we_i
//
// Key write: taken at its handshake. Crypt: CR_A to CR_E before the next
// request, set by the dependent reads and swap writes on the sbox memory's
// single read and single write port. Schedule: 256 rounds of KS_A to KS_C.
// Reset restores the identity sbox through per-entry valid bits at once.
// A stalled response holds in its register; key writes and schedules still
// proceed behind it, a further crypt waits for the register to free.
// Top level of the RC4 engine; depends on rc4_pkg, the channel interfaces,
// rc4_ctrl, rc4_sbox_ram and rc4_key_ram.
module rc4_stream_cipher #(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rc4_req_if.sink                       req_i,
  rc4_rsp_if.source                     rsp_o,
  input  logic                          key_length_we_i,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] key_length_i
);
  import rc4_pkg::*;

  localparam int unsigned KeyAw = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic [KEY_LEN_W-1:0] key_length_q;
  sbox_req_t            sbox_req;
  logic [BYTE_W-1:0]    sbox_rd_data;
  logic                 key_we;
  logic [KeyAw-1:0]     key_waddr;
  logic [BYTE_W-1:0]    key_wdata;
  logic                 key_re;
  logic [KeyAw-1:0]     key_raddr;
  logic [BYTE_W-1:0]    key_rd_data;

  // Key length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LEN_RESET;
    end else if (key_length_we_i) begin
      key_length_q <= key_length_i;
    end
  end

  rc4_ctrl #(
    .KEY_MAX (KEY_MAX)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .rsp_o          (rsp_o),
    .key_length_i   (key_length_q),
    .sbox_req_o     (sbox_req),
    .sbox_rd_data_i (sbox_rd_data),
    .key_we_o       (key_we),
    .key_waddr_o    (key_waddr),
    .key_wdata_o    (key_wdata),
    .key_re_o       (key_re),
    .key_raddr_o    (key_raddr),
    .key_rd_data_i  (key_rd_data)
  );

  rc4_sbox_ram u_sbox (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sbox_req),
    .rd_data_o (sbox_rd_data)
  );

  rc4_key_ram #(
    .KEY_MAX (KEY_MAX)
  ) u_key (
    .clk_i     (clk_i),
    .wr_en_i   (key_we),
    .wr_addr_i (key_waddr),
    .wr_data_i (key_wdata),
    .rd_en_i   (key_re),
    .rd_addr_i (key_raddr),
    .rd_data_o (key_rd_data)
  );

endmodule

@@ rtl/core/rc4_stream_cipher_chk.sv @@
// Port-level checker for the RC4 engine, bound to the top level.
// Depends on rc4_pkg and rc4_stream_cipher_macros.svh.
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic [1:0]                 req_command_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [rc4_pkg::BYTE_W-1:0] rsp_data_out_i,
  input logic                       rsp_last_out_i
);
  import rc4_pkg::*;

  logic       req_acc;
  logic       rsp_acc;
  logic       crypt_acc;
  logic [1:0] open_q;   // crypt requests not yet answered

  assign req_acc   = req_valid_i && req_ready_i;
  assign rsp_acc   = rsp_valid_i && rsp_ready_i;
  assign crypt_acc = req_acc && (req_command_i == CMD_CRYPT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (crypt_acc && !rsp_acc) begin
      open_q <= open_q + 2'd1;
    end else if (rsp_acc && !crypt_acc) begin
      open_q <= open_q - 2'd1;
    end
  end

  // Handshake rules on the response side
  `RC4_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "response dropped")
  `RC4_ASSERT_NXT(a_rsp_stable, rsp_valid_i && !rsp_ready_i, $stable(rsp_data_out_i) && $stable(rsp_last_out_i), "stalled response changed")

  // Schedule and crypt requests occupy the engine
  `RC4_ASSERT_NXT(a_busy, req_acc && (req_command_i == CMD_SCHEDULE || req_command_i == CMD_CRYPT), !req_ready_i, "engine ready right after a long request")

  // Responses only answer crypt requests, at most two in flight
  `RC4_ASSERT_IMP(a_rsp_owed, rsp_acc, open_q != 2'd0, "response without crypt request")
  `RC4_ASSERT(a_open_bound, open_q != 2'd3, "too many crypt requests in flight")

endmodule

bind rc4_stream_cipher rc4_stream_cipher_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_command_i  (req_i.command),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_data_out_i (rsp_o.data_out),
  .rsp_last_out_i (rsp_o.last_out)
);
